/* hw/rtl/me_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// me_pkg: shared types and constants of the modular exponentiation block
// Field widths, register indexes and the status struct of the serial
// modular multiplier.
// ----------------------------------------------------------------------------
package me_pkg;

  // field widths
  localparam int MOD_W       = 30;
  localparam int BASE_W      = 31;
  localparam int EXP_FIELD_W = 31;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 31;

  // multiplier operand width, one bit is consumed per cycle
  localparam int MUL_W = 31;

  // defaults
  localparam int               EXP_BITS_DEFAULT = 31;
  localparam logic [MOD_W-1:0] MOD_RESET        = 30'd998244352;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE    = 2'd0,
    REG_MODULUS = 2'd1
  } reg_idx_e;

  // status of one serial modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/me_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// me_if: channel interfaces of the modular exponentiation block
// Exponent request, result response and configuration write channels.
// ----------------------------------------------------------------------------

// exponent request channel
interface me_req_if import me_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [EXP_FIELD_W-1:0] exponent;

  modport source (output valid, output exponent, input ready);
  modport sink   (input valid, input exponent, output ready);
endinterface

// result channel
interface me_rsp_if import me_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] power_mod;

  modport source (output valid, output power_mod, input ready);
  modport sink   (input valid, input power_mod, output ready);
endinterface

// configuration write channel
interface me_cfg_if import me_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/modular_exponentiation.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_exponentiation: base ^ exponent mod modulus per request
// Right-to-left binary square-and-multiply over two bit-serial modular
// multipliers, one squaring and one accumulating.
// ----------------------------------------------------------------------------
// channel  dir  payload         handshake
// cfg_i    in   index, data     valid/ready, always ready
// req_i    in   exponent        valid/ready, ready while no request in work
// rsp_o    out  power_mod       valid/ready, held in an output register
//
// A request first reduces the base (one multiply), then spends one multiply
// per exponent bit up to its highest set bit; the result is written to the
// output register from ST_FIN, which waits while the held response is not
// taken, and the sequencer then returns to idle for the next request.
// Modulus below 2 skips the multiplies and answers 0.
// Reset restores base 0 and modulus 998244352 and idles the sequencer.
// A stalled response does not block the next request, only its finish.
// ----------------------------------------------------------------------------
module modular_exponentiation import me_pkg::*; #(
  parameter int EXP_BITS = EXP_BITS_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  me_cfg_if.sink    cfg_i,
  me_req_if.sink    req_i,
  me_rsp_if.source  rsp_o
);

  localparam int EXP_W = (EXP_BITS < EXP_FIELD_W) ? EXP_BITS : EXP_FIELD_W;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_REDUCE = 4'b0010,
    ST_MULT   = 4'b0100,
    ST_FIN    = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [BASE_W-1:0] base_q;
  logic [MOD_W-1:0]  mod_q;
  logic [EXP_W-1:0]  exp_q, exp_shr;
  logic [MOD_W-1:0]  acc_q, acc_next;
  logic              rsp_valid_q;
  logic [MOD_W-1:0]  rsp_data_q;
  logic              req_fire, rsp_free, mod_small;

  logic             sq_start, acc_start;
  logic [MOD_W-1:0] sq_a, sq_res, acc_res;
  logic [MUL_W-1:0] sq_b, acc_b;
  mm_stat_t         sq_stat, acc_stat;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      mod_q  <= MOD_RESET;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_BASE:    base_q <= cfg_i.data[BASE_W-1:0];
        REG_MODULUS: mod_q  <= cfg_i.data[MOD_W-1:0];
        default:     ;
      endcase
    end
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign rsp_free    = !rsp_valid_q || rsp_o.ready;
  assign mod_small   = (mod_q < MOD_W'(2));
  assign exp_shr     = exp_q >> 1;

  // accumulator takes the product only for a set exponent bit of a multiply step
  assign acc_next = (state_q == ST_MULT && exp_q[0]) ? acc_res : acc_q;

  // multiplier operands: base reduction first, then square and accumulate
  assign sq_start  = (req_fire && !mod_small)
                  || (state_q == ST_REDUCE && sq_stat.done && exp_q != '0)
                  || (state_q == ST_MULT && sq_stat.done && exp_shr != '0);
  assign acc_start = sq_start && (state_q != ST_IDLE);
  assign sq_a      = (state_q == ST_IDLE) ? MOD_W'(1) : sq_res;
  assign sq_b      = (state_q == ST_IDLE) ? MUL_W'(base_q)
                                          : {{(MUL_W-MOD_W){1'b0}}, sq_res};
  assign acc_b     = {{(MUL_W-MOD_W){1'b0}}, sq_res};

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = mod_small ? ST_FIN : ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (sq_stat.done) begin
          state_d = (exp_q == '0) ? ST_FIN : ST_MULT;
        end
      end
      ST_MULT: begin
        if (sq_stat.done && exp_shr == '0) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (rsp_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      exp_q <= req_i.exponent[EXP_W-1:0];
      acc_q <= mod_small ? '0 : MOD_W'(1);
    end else if (state_q == ST_MULT && sq_stat.done) begin
      acc_q <= acc_next;
      exp_q <= exp_shr;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (state_q == ST_FIN && rsp_free) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN && rsp_free) begin
      rsp_data_q <= acc_q;
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.power_mod = rsp_data_q;

  // squaring unit, also reduces the base
  me_modmul u_sq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .a_i    (sq_a),
    .b_i    (sq_b),
    .m_i    (mod_q),
    .stat_o (sq_stat),
    .res_o  (sq_res)
  );

  // accumulating unit
  me_modmul u_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(acc_start),
    .a_i    (acc_next),
    .b_i    (acc_b),
    .m_i    (mod_q),
    .stat_o (acc_stat),
    .res_o  (acc_res)
  );

  // checks
  a_mult_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MULT |-> exp_q != '0)
    else $error("multiply step with no exponent bits left");

  a_units_in_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MULT |-> sq_stat.busy == acc_stat.busy)
    else $error("multipliers out of step");

  a_acc_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MULT || state_q == ST_REDUCE) |-> acc_q < mod_q)
    else $error("accumulator not reduced");

  a_done_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_stat.done |-> (state_q == ST_REDUCE || state_q == ST_MULT))
    else $error("multiplier done outside of work");

endmodule
`default_nettype wire

/* hw/rtl/me_modmul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// me_modmul: bit-serial modular multiplier
// Computes a * b mod m by interleaved shift-and-add, one bit of b per cycle
// from the top, reducing the partial result below m at every step.
// Requires a < m and m >= 2.
// ----------------------------------------------------------------------------
module me_modmul import me_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [MOD_W-1:0] a_i,
  input  wire logic [MUL_W-1:0] b_i,
  input  wire logic [MOD_W-1:0] m_i,
  output mm_stat_t              stat_o,
  output logic [MOD_W-1:0]      res_o
);

  localparam int CNT_W = $clog2(MUL_W + 1);
  localparam int SUM_W = MOD_W + 2;

  logic [CNT_W-1:0] cnt_q;
  logic             done_q;
  logic [MOD_W-1:0] a_q, m_q, r_q, r_d;
  logic [MUL_W-1:0] b_q;
  logic [SUM_W-1:0] sum, m1, m2;

  // one step: r = 2r + bit * a, then bring back below m
  always_comb begin
    m1  = {2'b00, m_q};
    m2  = {1'b0, m_q, 1'b0};
    sum = {1'b0, r_q, 1'b0} + (b_q[MUL_W-1] ? {2'b00, a_q} : '0);
    if (sum >= m2) begin
      sum = sum - m2;
    end else if (sum >= m1) begin
      sum = sum - m1;
    end
    r_d = sum[MOD_W-1:0];
  end

  // step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_W'(MUL_W);
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // operand and partial result registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      m_q <= m_i;
      r_q <= '0;
    end else if (cnt_q != '0) begin
      b_q <= {b_q[MUL_W-2:0], 1'b0};
      r_q <= r_d;
    end
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign res_o       = r_q;

  // checks
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> cnt_q == '0)
    else $error("multiplier started while busy");

  a_done_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> r_q < m_q)
    else $error("multiplier result not reduced");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CNT_W'(1) && !start_i) |=> done_q)
    else $error("missing done after last step");

endmodule
`default_nettype wire

/* dv/tb_modular_exponentiation.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_exponentiation: self-checking bench for the exponentiation block
// Sends exponent requests and register writes over the valid/ready channels.
// Every power_mod is predicted by a square-and-multiply model kept inside
// the bench and checked in order, with random stalls on both sides and one
// long result hold-off that backs up the request channel.
// ----------------------------------------------------------------------------
module tb_modular_exponentiation;
  import me_pkg::*;

  localparam int EXP_BITS        = EXP_BITS_DEFAULT;
  localparam int CLK_HALF        = 4;
  localparam int N_PHASES        = 12;
  localparam int ITEMS_PER_PHASE = 104;
  localparam int PRESSURE_PHASE  = 5;
  localparam int PRESSURE_ITEMS  = 12;
  localparam int HOLD_CYCLES     = 3000;
  localparam int DRAIN_CYCLES    = 64;
  localparam int IDLE_LIMIT      = 20000;
  localparam int MAX_REPORTS     = 20;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0]   REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0]   REG_SPARE_3 = 2'd3;
  localparam logic [EXP_FIELD_W-1:0] EXP_MAX     = '1;
  localparam logic [CFG_DATA_W-1:0]  DATA_MAX    = '1;
  localparam logic [MOD_W-1:0]       MOD_MAX     = '1;

  typedef enum logic [1:0] {
    CHK_OK,
    CHK_UNEXPECTED,
    CHK_MISMATCH
  } chk_e;

  // expected powers in request order, with a private copy of the registers
  class power_scoreboard;
    logic [BASE_W-1:0] base;
    logic [MOD_W-1:0]  modulus;
    logic [MOD_W-1:0]  power_q[$];
    int unsigned       n_requests;
    int unsigned       n_results;

    function new();
      base       = '0;
      modulus    = MOD_RESET;
      n_requests = 0;
      n_results  = 0;
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BASE:    base = data[BASE_W-1:0];
        REG_MODULUS: modulus = data[MOD_W-1:0];
        default: ;
      endcase
    endfunction

    // right-to-left square-and-multiply, products fit in 60 bits
    function logic [MOD_W-1:0] mod_power(input logic [EXP_FIELD_W-1:0] e);
      logic [63:0] m;
      logic [63:0] acc;
      logic [63:0] sq;
      if (modulus < 2) return '0;
      m   = modulus;
      acc = 64'd1 % m;
      sq  = base;
      sq  = sq % m;
      for (int i = 0; i < EXP_BITS && i < EXP_FIELD_W; i++) begin
        if (e[i]) acc = (acc * sq) % m;
        sq = (sq * sq) % m;
      end
      return acc[MOD_W-1:0];
    endfunction

    function void note_request(input logic [EXP_FIELD_W-1:0] e);
      power_q.push_back(mod_power(e));
      n_requests++;
    endfunction

    function chk_e check_result(input logic [MOD_W-1:0] got,
                                output logic [MOD_W-1:0] want);
      want = '0;
      if (power_q.size() == 0) return CHK_UNEXPECTED;
      want = power_q.pop_front();
      n_results++;
      return (got === want) ? CHK_OK : CHK_MISMATCH;
    endfunction

    function int unsigned pending();
      return power_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  me_cfg_if cfg_if ();
  me_req_if req_if ();
  me_rsp_if rsp_if ();

  power_scoreboard sb = new();

  int unsigned      n_errors = 0;
  int unsigned      n_writes = 0;
  bit               no_idle  = 1'b0;
  bit               hold_rsp = 1'b0;
  chk_e             status;
  logic [MOD_W-1:0] want;

  modular_exponentiation #(.EXP_BITS(EXP_BITS)) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
  endtask

  // random helpers
  function automatic logic [CFG_DATA_W-1:0] rand_data();
    logic [31:0] raw;
    raw = $urandom;
    return raw[CFG_DATA_W-1:0];
  endfunction

  // mostly short exponents, some up to the full width, top bit forced
  function automatic logic [EXP_FIELD_W-1:0] rand_exponent(input int unsigned max_len);
    int unsigned            len;
    logic [31:0]            raw;
    logic [EXP_FIELD_W-1:0] e;
    raw = $urandom;
    if (max_len <= 12) len = $urandom_range(0, max_len);
    else if ($urandom_range(0, 9) < 6) len = $urandom_range(0, 12);
    else len = $urandom_range(13, max_len);
    e = raw[EXP_FIELD_W-1:0] >> (EXP_FIELD_W - len);
    if (len != 0) e[len-1] = 1'b1;
    return e;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_modulus_data();
    int unsigned           len;
    logic [CFG_DATA_W-1:0] d;
    d = rand_data();
    case ($urandom_range(0, 19))
      0: d = '0;
      1: d = 31'd1;
      2: d = 31'd2;
      3: d = {1'b0, MOD_MAX};
      4: d = {1'b0, MOD_RESET};
      // bit above the modulus width is dropped by the register
      5: d = d | {1'b1, {MOD_W{1'b0}}};
      default: begin
        len = $urandom_range(2, MOD_W);
        d = d >> (CFG_DATA_W - len);
        d[len-1] = 1'b1;
      end
    endcase
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_base(input logic [MOD_W-1:0] m);
    logic [CFG_DATA_W-1:0] b;
    b = rand_data();
    case ($urandom_range(0, 9))
      0: b = '0;
      1: b = 31'd1;
      2: b = DATA_MAX;
      3: b = {1'b0, m} - 1'b1;
      4: b = {1'b0, m};
      default: ;
    endcase
    return b;
  endfunction

  // drivers
  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
                         input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    n_writes++;
  endtask

  task automatic close_cfg();
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_exponent(input logic [EXP_FIELD_W-1:0] e);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.exponent <= e;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  // stop requesting and wait for every expected power
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // monitor: register writes, accepted requests, checked results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (req_if.valid && req_if.ready) sb.note_request(req_if.exponent);
      if (rsp_if.valid && rsp_if.ready) begin
        status = sb.check_result(rsp_if.power_mod, want);
        if (status == CHK_UNEXPECTED) begin
          report_mismatch($sformatf("power_mod %0d with no request pending",
                                    rsp_if.power_mod));
        end else if (status == CHK_MISMATCH) begin
          report_mismatch($sformatf("power_mod %0d, expected %0d (base %0d modulus %0d)",
                                    rsp_if.power_mod, want, sb.base, sb.modulus));
        end
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_rsp) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rsp = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
    end
  end

  // watchdog on cycles with no handshake at all
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((cfg_if.valid && cfg_if.ready) || (req_if.valid && req_if.ready) ||
          (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    logic [CFG_DATA_W-1:0] mod_data;
    logic [CFG_DATA_W-1:0] base_data;
    int unsigned           n_items;
    rst_ni          <= 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= REG_BASE;
    cfg_if.data     <= '0;
    req_if.valid    <= 1'b0;
    req_if.exponent <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset registers: zero base, default modulus, zero exponent still gives 1
    send_exponent('0);
    send_exponent(31'd1);
    send_exponent(EXP_MAX);
    settle();

    // small base against exponent extremes and bit patterns
    set_reg(REG_BASE, 31'd3);
    close_cfg();
    send_exponent('0);
    send_exponent(31'd1);
    send_exponent(31'd2);
    send_exponent(EXP_MAX);
    send_exponent(31'h4000_0000);
    send_exponent(31'h5555_5555);
    send_exponent(31'h2AAA_AAAA);
    settle();

    // largest base, largest modulus with the dropped top data bit set
    set_reg(REG_BASE, DATA_MAX);
    set_reg(REG_MODULUS, DATA_MAX);
    close_cfg();
    send_exponent(EXP_MAX);
    send_exponent(31'd1);
    send_exponent(31'd2);
    settle();

    // smallest legal modulus
    set_reg(REG_MODULUS, 31'd2);
    set_reg(REG_BASE, 31'd5);
    close_cfg();
    send_exponent('0);
    send_exponent(31'd1);
    send_exponent(EXP_MAX);
    settle();

    // modulus one reduces everything to zero
    set_reg(REG_MODULUS, 31'd1);
    close_cfg();
    send_exponent('0);
    send_exponent(31'd7);
    settle();

    // modulus zero has no residue, answers zero
    set_reg(REG_MODULUS, '0);
    close_cfg();
    send_exponent('0);
    send_exponent(EXP_MAX);
    settle();

    // writes to unused indexes must leave both registers alone
    set_reg(REG_MODULUS, 31'd13);
    set_reg(REG_SPARE_2, 31'd4);
    set_reg(REG_SPARE_3, DATA_MAX);
    close_cfg();
    send_exponent(31'd2);
    settle();

    // random phases, each under fresh register settings
    for (int p = 0; p < N_PHASES; p++) begin
      mod_data  = rand_modulus_data();
      base_data = rand_base(mod_data[MOD_W-1:0]);
      if ($urandom_range(0, 1) != 0) begin
        set_reg(REG_BASE, base_data);
        set_reg(REG_MODULUS, mod_data);
      end else begin
        set_reg(REG_MODULUS, mod_data);
        set_reg(REG_BASE, base_data);
      end
      if ($urandom_range(0, 3) == 0) begin
        set_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_2 : REG_SPARE_3, rand_data());
      end
      close_cfg();
      no_idle = (p % 4 == 1);
      n_items = 0;
      // hold results back while requests keep coming, block must stall
      if (p == PRESSURE_PHASE) begin
        no_idle  = 1'b1;
        hold_rsp = 1'b1;
        repeat (PRESSURE_ITEMS) send_exponent(rand_exponent(4));
        n_items = PRESSURE_ITEMS;
      end
      while (n_items < ITEMS_PER_PHASE) begin
        send_exponent(rand_exponent(EXP_FIELD_W));
        n_items++;
      end
      settle();
    end

    no_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d exponent requests, %0d results checked, %0d register writes",
             sb.n_requests, sb.n_results, n_writes);
    $display("with random stalls, a long result hold-off and %0d mismatches", n_errors);
    if (n_errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
